FILE: design/saf_pkg.sv
package saf_pkg;

  // pipeline depths
  localparam int ROOT_STEPS = 32;  // one root bit per stage
  localparam int QUO_BITS   = 31;  // one quotient bit per stage
  localparam int LATENCY    = 4 + ROOT_STEPS + QUO_BITS + 1;

  // configuration register indexes
  localparam logic [7:0] REG_MAX_SPEED   = 8'd0;
  localparam logic [7:0] REG_SLOW_RADIUS = 8'd1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] dest_x;
    logic signed [31:0] dest_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } saf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               saturated;
  } saf_out_t;

  // travels alongside the divider
  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               sat;
  } saf_side_t;

  // travels alongside the square root
  typedef struct packed {
    logic [61:0] num_x;
    logic [61:0] num_y;
    logic        arrive;
    saf_side_t   side;
  } saf_sqt_t;

endpackage

FILE: design/steering_arrive_force.sv
// Arrive steering force, one agent per beat.
// Input: a beat is taken at a clock edge with start_i high and busy_o low.
//   busy_o stays low, so a new agent may be started every cycle.
// Output: each result sits on result_o for exactly one cycle, marked by
//   done_o. Results leave in input order, one per input.
// Config: cfg_valid_i/cfg_ready_o write max_speed (index 0) or
//   slowing_radius (index 1); other indexes are dropped. cfg_ready_o is
//   always high. Write only while no agent is in flight.
// Throughput: one agent per cycle. Latency is set by the 32-stage square
//   root (one root bit per stage) and the 31-stage divider (one quotient
//   bit per stage), plus four front stages and the output register.
// Reset: clears all stage valid bits and loads max_speed = 1.0,
//   slowing_radius = 0 (plain seek). Results cannot be held off by the
//   receiver, so nothing in the pipe ever stalls.
module steering_arrive_force (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  saf_pkg::saf_in_t operand_i,
  output logic             done_o,
  output saf_pkg::saf_out_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  logic [30:0] max_speed_q, radius_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= 31'd65536;
      radius_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == saf_pkg::REG_MAX_SPEED) begin
        max_speed_q <= cfg_data_i[30:0];
      end else if (cfg_index_i == saf_pkg::REG_SLOW_RADIUS) begin
        radius_q <= cfg_data_i[30:0];
      end
    end
  end

  // stage 0: input capture
  logic             s0_vld_q;
  saf_pkg::saf_in_t s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= operand_i;
  end

  // stage 1: clipped delta and its magnitude
  logic signed [32:0] dx_w, dy_w;
  logic signed [31:0] dx_c, dy_c;
  logic               satx_c, saty_c;
  logic               s1_vld_q;
  logic [31:0]        s1_ax_q, s1_ay_q;
  saf_pkg::saf_side_t s1_side_q;

  assign dx_w = {s0_q.dest_x[31], s0_q.dest_x} - {s0_q.pos_x[31], s0_q.pos_x};
  assign dy_w = {s0_q.dest_y[31], s0_q.dest_y} - {s0_q.pos_y[31], s0_q.pos_y};

  always_comb begin
    satx_c = (dx_w[32] != dx_w[31]);
    saty_c = (dy_w[32] != dy_w[31]);
    dx_c   = satx_c ? {dx_w[32], {31{~dx_w[32]}}} : dx_w[31:0];
    dy_c   = saty_c ? {dy_w[32], {31{~dy_w[32]}}} : dy_w[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ax_q         <= dx_c[31] ? (~dx_c + 32'd1) : dx_c;
    s1_ay_q         <= dy_c[31] ? (~dy_c + 32'd1) : dy_c;
    s1_side_q.neg_x <= dx_c[31];
    s1_side_q.neg_y <= dy_c[31];
    s1_side_q.vel_x <= s0_q.vel_x;
    s1_side_q.vel_y <= s0_q.vel_y;
    s1_side_q.sat   <= satx_c || saty_c;
  end

  // stage 2: squares and speed products
  logic               s2_vld_q;
  logic [63:0]        s2_sqx_q, s2_sqy_q;
  logic [61:0]        s2_r2_q, s2_numx_q, s2_numy_q;
  saf_pkg::saf_side_t s2_side_q;
  logic [62:0]        px_w, py_w;

  assign px_w = 63'(s1_ax_q) * 63'(max_speed_q);
  assign py_w = 63'(s1_ay_q) * 63'(max_speed_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sqx_q  <= 64'(s1_ax_q) * 64'(s1_ax_q);
    s2_sqy_q  <= 64'(s1_ay_q) * 64'(s1_ay_q);
    s2_r2_q   <= 62'(radius_q) * 62'(radius_q);
    s2_numx_q <= px_w[61:0];
    s2_numy_q <= py_w[61:0];
    s2_side_q <= s1_side_q;
  end

  // stage 3: squared length and slowing-zone test
  logic              s3_vld_q;
  logic [63:0]       s3_sum_q;
  saf_pkg::saf_sqt_t s3_tag_q;
  logic [63:0]       sum_c;

  assign sum_c = s2_sqx_q + s2_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sum_q        <= sum_c;
    s3_tag_q.num_x  <= s2_numx_q;
    s3_tag_q.num_y  <= s2_numy_q;
    s3_tag_q.arrive <= (sum_c < {2'b00, s2_r2_q});
    s3_tag_q.side   <= s2_side_q;
  end

  // length
  logic              rt_vld;
  logic [31:0]       rt_len;
  saf_pkg::saf_sqt_t rt_tag;

  saf_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s3_vld_q),
    .radicand_i (s3_sum_q),
    .tag_i      (s3_tag_q),
    .valid_o    (rt_vld),
    .root_o     (rt_len),
    .tag_o      (rt_tag)
  );

  // divisor: radius inside the slowing zone, else length (zero length has
  // a zero numerator, so any nonzero divisor gives zero)
  logic [31:0] den_c;

  always_comb begin
    if (rt_tag.arrive) begin
      den_c = {1'b0, radius_q};
    end else if (rt_len == '0) begin
      den_c = 32'd1;
    end else begin
      den_c = rt_len;
    end
  end

  logic               dv_vld;
  logic [30:0]        qx, qy;
  saf_pkg::saf_side_t dv_side;

  saf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_vld),
    .num_x_i (rt_tag.num_x),
    .num_y_i (rt_tag.num_y),
    .den_i   (den_c),
    .side_i  (rt_tag.side),
    .valid_o (dv_vld),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .side_o  (dv_side)
  );

  // output stage: restore sign, subtract velocity, saturate
  logic signed [33:0] wx_c, wy_c, fx_c, fy_c;
  logic               ofx_c, ofy_c;
  logic               done_q;
  saf_pkg::saf_out_t  res_q;

  always_comb begin
    wx_c  = dv_side.neg_x ? -$signed({3'b000, qx}) : $signed({3'b000, qx});
    wy_c  = dv_side.neg_y ? -$signed({3'b000, qy}) : $signed({3'b000, qy});
    fx_c  = wx_c - {{2{dv_side.vel_x[31]}}, dv_side.vel_x};
    fy_c  = wy_c - {{2{dv_side.vel_y[31]}}, dv_side.vel_y};
    ofx_c = (fx_c[33:31] != 3'b000) && (fx_c[33:31] != 3'b111);
    ofy_c = (fy_c[33:31] != 3'b000) && (fy_c[33:31] != 3'b111);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.force_x   <= ofx_c ? {fx_c[33], {31{~fx_c[33]}}} : fx_c[31:0];
    res_q.force_y   <= ofy_c ? {fy_c[33], {31{~fy_c[33]}}} : fy_c[31:0];
    res_q.saturated <= dv_side.sat || ofx_c || ofy_c;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // every result comes from an accepted beat a fixed latency earlier
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, saf_pkg::LATENCY))
    else $error("result without matching input beat");

  // zero radius must never select the slowing zone
  a_seek : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_vld_q && s3_tag_q.arrive) |-> (radius_q != '0))
    else $error("slowing zone taken with zero radius");

  // desired components never exceed max_speed
  a_quo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld |-> ((qx <= max_speed_q) && (qy <= max_speed_q)))
    else $error("desired speed above max_speed");

endmodule

FILE: design/saf_isqrt.sv
// Pipelined floor square root, one result bit per stage
module saf_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [63:0]        radicand_i,
  input  saf_pkg::saf_sqt_t  tag_i,
  output logic               valid_o,
  output logic [31:0]        root_o,
  output saf_pkg::saf_sqt_t  tag_o
);

  logic              vld_q  [1:saf_pkg::ROOT_STEPS];
  logic [63:0]       rad_q  [1:saf_pkg::ROOT_STEPS];
  logic [33:0]       rem_q  [1:saf_pkg::ROOT_STEPS];
  logic [31:0]       root_q [1:saf_pkg::ROOT_STEPS];
  saf_pkg::saf_sqt_t tag_q  [1:saf_pkg::ROOT_STEPS];

  for (genvar k = 0; k < saf_pkg::ROOT_STEPS; k++) begin : g_step
    logic              vld_c;
    logic [63:0]       rad_c;
    logic [33:0]       rem_c;
    logic [31:0]       root_c;
    saf_pkg::saf_sqt_t tag_c;
    logic [35:0]       cur, trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign rad_c  = radicand_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign tag_c  = tag_i;
    end else begin : g_rest
      assign vld_c  = vld_q[k];
      assign rad_c  = rad_q[k];
      assign rem_c  = rem_q[k];
      assign root_c = root_q[k];
      assign tag_c  = tag_q[k];
    end

    // bring down two radicand bits, try 4r+1
    assign cur   = {rem_c, rad_c[63:62]};
    assign trial = {2'b00, root_c, 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= {rad_c[61:0], 2'b00};
      rem_q[k+1]  <= ge ? diff[33:0] : cur[33:0];
      root_q[k+1] <= {root_c[30:0], ge};
      tag_q[k+1]  <= tag_c;
    end
  end

  assign valid_o = vld_q[saf_pkg::ROOT_STEPS];
  assign root_o  = root_q[saf_pkg::ROOT_STEPS];
  assign tag_o   = tag_q[saf_pkg::ROOT_STEPS];

endmodule

FILE: design/saf_div.sv
// Pipelined restoring divider, two numerators over one divisor,
// one quotient bit per stage. Quotient is known to fit QUO_BITS.
module saf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [61:0]        num_x_i,
  input  logic [61:0]        num_y_i,
  input  logic [31:0]        den_i,
  input  saf_pkg::saf_side_t side_i,
  output logic               valid_o,
  output logic [30:0]        quo_x_o,
  output logic [30:0]        quo_y_o,
  output saf_pkg::saf_side_t side_o
);

  logic               vld_q  [1:saf_pkg::QUO_BITS];
  logic [61:0]        remx_q [1:saf_pkg::QUO_BITS];
  logic [61:0]        remy_q [1:saf_pkg::QUO_BITS];
  logic [30:0]        qx_q   [1:saf_pkg::QUO_BITS];
  logic [30:0]        qy_q   [1:saf_pkg::QUO_BITS];
  logic [31:0]        den_q  [1:saf_pkg::QUO_BITS];
  saf_pkg::saf_side_t side_q [1:saf_pkg::QUO_BITS];

  for (genvar k = 0; k < saf_pkg::QUO_BITS; k++) begin : g_step
    localparam int Bit = saf_pkg::QUO_BITS - 1 - k;
    logic               vld_c;
    logic [61:0]        remx_c, remy_c;
    logic [30:0]        qx_c, qy_c;
    logic [31:0]        den_c;
    saf_pkg::saf_side_t side_c;
    logic [62:0]        dsh, subx, suby;
    logic               gex, gey;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign remx_c = num_x_i;
      assign remy_c = num_y_i;
      assign qx_c   = '0;
      assign qy_c   = '0;
      assign den_c  = den_i;
      assign side_c = side_i;
    end else begin : g_rest
      assign vld_c  = vld_q[k];
      assign remx_c = remx_q[k];
      assign remy_c = remy_q[k];
      assign qx_c   = qx_q[k];
      assign qy_c   = qy_q[k];
      assign den_c  = den_q[k];
      assign side_c = side_q[k];
    end

    // compare each remainder against the divisor at this bit weight
    assign dsh  = {31'b0, den_c} << Bit;
    assign gex  = ({1'b0, remx_c} >= dsh);
    assign gey  = ({1'b0, remy_c} >= dsh);
    assign subx = {1'b0, remx_c} - dsh;
    assign suby = {1'b0, remy_c} - dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      remx_q[k+1] <= gex ? subx[61:0] : remx_c;
      remy_q[k+1] <= gey ? suby[61:0] : remy_c;
      qx_q[k+1]   <= {qx_c[29:0], gex};
      qy_q[k+1]   <= {qy_c[29:0], gey};
      den_q[k+1]  <= den_c;
      side_q[k+1] <= side_c;
    end
  end

  assign valid_o = vld_q[saf_pkg::QUO_BITS];
  assign quo_x_o = qx_q[saf_pkg::QUO_BITS];
  assign quo_y_o = qy_q[saf_pkg::QUO_BITS];
  assign side_o  = side_q[saf_pkg::QUO_BITS];

endmodule

FILE: tb/tb_steering_arrive_force.sv
`timescale 1ns / 1ps

module tb_steering_arrive_force;

  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 500;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  saf_pkg::saf_in_t  operand_i = '0;
  logic       done_o;
  saf_pkg::saf_out_t result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  steering_arrive_force u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .operand_i(operand_i), .done_o(done_o), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor's copy of the registers
  logic [30:0] speed_q = 31'd65536;
  logic [30:0] radius_q = 31'd0;

  saf_pkg::saf_out_t force_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;

  function automatic logic [31:0] isqrt64(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res[31:0];
  endfunction

  function automatic longint scale_by(longint d, logic [63:0] den);
    logic [63:0] mag, q;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    q = (mag * 64'(speed_q)) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, ref logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic saf_pkg::saf_out_t arrive_force(saf_pkg::saf_in_t a);
    saf_pkg::saf_out_t r;
    logic sat;
    longint dx, dy, wx, wy;
    logic [63:0] ax, ay, s, r2;
    sat = 1'b0;
    dx = clip(longint'(a.dest_x) - longint'(a.pos_x), sat);
    dy = clip(longint'(a.dest_y) - longint'(a.pos_y), sat);
    ax = (dx < 0) ? 64'(-dx) : 64'(dx);
    ay = (dy < 0) ? 64'(-dy) : 64'(dy);
    s = ax * ax + ay * ay;
    r2 = 64'(radius_q) * 64'(radius_q);
    wx = 0;
    wy = 0;
    if (s < r2) begin
      wx = scale_by(dx, 64'(radius_q));
      wy = scale_by(dy, 64'(radius_q));
    end else if (s != 0) begin
      wx = scale_by(dx, 64'(isqrt64(s)));
      wy = scale_by(dy, 64'(isqrt64(s)));
    end
    r.force_x = 32'(clip(wx - longint'(a.vel_x), sat));
    r.force_y = 32'(clip(wy - longint'(a.vel_y), sat));
    r.saturated = sat;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (force_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        saf_pkg::saf_out_t e;
        e = force_q.pop_front();
        if (result_o.force_x !== e.force_x || result_o.force_y !== e.force_y ||
            result_o.saturated !== e.saturated) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, result_o);
        end
      end
    end
  end

  // watchdog on cycles with no beat
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // start_i stays high between back-to-back beats; a gap drops it first
  task automatic send_agent(saf_pkg::saf_in_t a, bit has_exp, saf_pkg::saf_out_t exp_r);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    operand_i <= a;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (has_exp) force_q.push_back(exp_r);
    else force_q.push_back(arrive_force(a));
  endtask

  task automatic drain_pipe();
    start_i <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (saf_pkg::LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == saf_pkg::REG_MAX_SPEED) speed_q = val[30:0];
    else if (idx == saf_pkg::REG_SLOW_RADIUS) radius_q = val[30:0];
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
    endcase
  endfunction

  typedef struct {
    saf_pkg::saf_in_t  a;
    bit                has_exp;
    saf_pkg::saf_out_t r;
  } agent_row_t;

  localparam logic [31:0] SMAX = 32'h7FFFFFFF;
  localparam logic [31:0] SMIN = 32'h80000000;

  initial begin
    agent_row_t rows[$];
    saf_pkg::saf_in_t a;
    rows = '{
      // zero delta, zero velocity
      '{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0}},
      // zero delta: force is minus velocity
      '{'{5, 7, 5, 7, 32'd100, -32'sd200}, 1, '{-32'sd100, 32'd200, 0}},
      // unit seeks along x and along -y at default speed
      '{'{0, 0, 32'd65536, 0, 0, 0}, 1, '{32'd65536, 0, 0}},
      '{'{0, 0, 0, -32'sd65536, 0, 0}, 1, '{0, -32'sd65536, 0}},
      // huge delta clips
      '{'{SMIN, SMAX, SMAX, SMIN, 0, 0}, 0, '{0, 0, 0}},
      // negated minimum velocity clips
      '{'{0, 0, 0, 0, SMIN, SMIN}, 1, '{SMAX, SMAX, 1}},
      '{'{0, 0, 0, 0, SMAX, SMAX}, 1, '{-32'sd2147483647, -32'sd2147483647, 0}},
      '{'{SMAX, SMIN, SMIN, SMAX, SMIN, SMAX}, 0, '{0, 0, 0}},
      '{'{0, 0, 3, 4, 1, 1}, 0, '{0, 0, 0}},
      '{'{-32'sd1, 0, 32'd1, 32'd1, 0, 0}, 0, '{0, 0, 0}}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_agent(rows[i].a, rows[i].has_exp, rows[i].r);
    drain_pipe();

    // arrive zone, extremes of the registers, dropped index
    write_reg(saf_pkg::REG_SLOW_RADIUS, 32'd1000000);
    write_reg(8'd2, 32'hFFFFFFFF);
    send_agent('{0, 0, 32'd100, 0, 0, 0}, 0, '0);
    send_agent('{0, 0, 32'd999999, 0, 0, 0}, 0, '0);
    send_agent('{0, 0, 32'd1000000, 0, 0, 0}, 0, '0);
    drain_pipe();
    write_reg(saf_pkg::REG_MAX_SPEED, 32'hFFFFFFFF);
    write_reg(saf_pkg::REG_SLOW_RADIUS, 32'hFFFFFFFF);
    send_agent('{SMIN, 0, SMAX, 0, SMAX, SMIN}, 0, '0);
    send_agent('{0, 0, 32'd1, 32'd1, 0, 0}, 0, '0);
    drain_pipe();
    write_reg(saf_pkg::REG_MAX_SPEED, 32'd0);
    write_reg(saf_pkg::REG_SLOW_RADIUS, 32'd1);
    send_agent('{0, 0, 32'd77, -32'sd5, 32'd3, 32'd4}, 0, '0);
    drain_pipe();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: write_reg(saf_pkg::REG_SLOW_RADIUS, 32'd0);
        1: write_reg(saf_pkg::REG_SLOW_RADIUS, $urandom_range(1, 3000000));
        2: write_reg(saf_pkg::REG_SLOW_RADIUS, $urandom());
        default: write_reg(saf_pkg::REG_SLOW_RADIUS, $urandom_range(0, 100));
      endcase
      write_reg(saf_pkg::REG_MAX_SPEED, (ph == 5) ? 32'h7FFFFFFF : $urandom());
      for (int k = 0; k < N_RANDOM / 10; k++) begin
        a.pos_x = rand_coord();
        a.pos_y = rand_coord();
        a.dest_x = ($urandom_range(0, 7) == 0) ? a.pos_x : rand_coord();
        a.dest_y = ($urandom_range(0, 7) == 0) ? a.pos_y : rand_coord();
        a.vel_x = $urandom();
        a.vel_y = $urandom_range(0, 1) ? $urandom() : rand_coord();
        send_agent(a, 0, '0);
      end
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/saf_pkg.sv
design/saf_isqrt.sv
design/saf_div.sv
design/steering_arrive_force.sv
tb/tb_steering_arrive_force.sv
